@@ rtl/core/tifd_pkg.sv @@
// shared types and format codes for the thumb instruction field decoder
package tifd_pkg;

  localparam int unsigned InstrWidth  = 16;
  localparam int unsigned ClassWidth  = 5;
  localparam int unsigned OutDataBits = 40;
  localparam int unsigned InDataBits  = 16;

  // format codes, thumb formats 1..19 in table order, then undefined
  localparam logic [ClassWidth-1:0] FMT_MOVE_SHIFTED = 5'd0;
  localparam logic [ClassWidth-1:0] FMT_ADD_SUB      = 5'd1;
  localparam logic [ClassWidth-1:0] FMT_MOV_CMP_IMM  = 5'd2;
  localparam logic [ClassWidth-1:0] FMT_ALU          = 5'd3;
  localparam logic [ClassWidth-1:0] FMT_HI_REG_BX    = 5'd4;
  localparam logic [ClassWidth-1:0] FMT_PC_LOAD      = 5'd5;
  localparam logic [ClassWidth-1:0] FMT_LS_REG_OFS   = 5'd6;
  localparam logic [ClassWidth-1:0] FMT_LS_SIGN_EXT  = 5'd7;
  localparam logic [ClassWidth-1:0] FMT_LS_IMM_OFS   = 5'd8;
  localparam logic [ClassWidth-1:0] FMT_LS_HALF      = 5'd9;
  localparam logic [ClassWidth-1:0] FMT_SP_LS        = 5'd10;
  localparam logic [ClassWidth-1:0] FMT_LOAD_ADDR    = 5'd11;
  localparam logic [ClassWidth-1:0] FMT_SP_OFFSET    = 5'd12;
  localparam logic [ClassWidth-1:0] FMT_PUSH_POP     = 5'd13;
  localparam logic [ClassWidth-1:0] FMT_MULTI_LS     = 5'd14;
  localparam logic [ClassWidth-1:0] FMT_COND_BRANCH  = 5'd15;
  localparam logic [ClassWidth-1:0] FMT_SWI          = 5'd16;
  localparam logic [ClassWidth-1:0] FMT_BRANCH       = 5'd17;
  localparam logic [ClassWidth-1:0] FMT_LONG_BRANCH  = 5'd18;
  localparam logic [ClassWidth-1:0] FMT_UNDEFINED    = 5'd19;

  typedef struct packed {
    logic [ClassWidth-1:0] format_class;
    logic [3:0]            op_code;
    logic [3:0]            dest_reg;
    logic [3:0]            src_reg;
    logic [2:0]            offset_reg;
    logic [10:0]           immediate;
    logic                  imm_is_reg;
    logic                  load_flag;
    logic                  size_flag;
    logic                  neg_or_sp;
    logic                  extra_flag;
    logic [7:0]            reg_list;
  } dec_t;

endpackage

@@ rtl/core/thumb_instruction_field_decoder_core.sv @@
// top level of the thumb instruction field decoder: input stage, decode, result stage
//
// usage
//   in_*  : one beat carries one 16-bit thumb instruction word in in_tdata
//   out_* : one beat per instruction; out_tuser is the format class
//           (thumb formats 1..19 as 0..18, 19 for undefined encodings),
//           out_tdata holds the decoded fields, unused fields read zero
//   path: a word accepted into the input register moves on into the result
//           register, which drives out_*; throughput: one instruction per cycle
//           while out_tready is high, set by the single decode pass between the two
//           registers; stall: when out_tready is low the result stays put; the input stage
//           keeps one more word, then in_tready drops until the result
//           is taken, so no beat is lost or repeated
//   reset: rst_n low clears both stage valid flags; no data is pending
//           afterwards and the block is ready at once
module thumb_instruction_field_decoder_core
  import tifd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input beat
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [InDataBits-1:0]  in_tdata,   // [15:0] instr_word
  // result beat
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OutDataBits-1:0] out_tdata,  // [3:0] op_code, [7:4] dest_reg,
                                             // [11:8] src_reg, [14:12] offset_reg,
                                             // [25:15] immediate, [26] imm_is_reg,
                                             // [27] load_flag, [28] size_flag,
                                             // [29] neg_or_sp, [30] extra_flag,
                                             // [38:31] reg_list, [39] zero
  output logic [ClassWidth-1:0]  out_tuser   // [4:0] format_class
);

  // input stage
  logic [InstrWidth-1:0] instr_r;
  logic                  in_vld_r;
  // result stage
  dec_t                  res_r;
  logic                  out_vld_r;

  dec_t                  dec;
  logic                  res_load;
  logic                  in_load;

  // result stage takes a new beat when empty or being drained this cycle
  assign res_load = !out_vld_r || out_tready;
  // input stage moves forward when it is empty or its word goes to the result stage
  assign in_load  = !in_vld_r || res_load;
  assign in_tready = in_load;

  tifd_decode u_decode (
    .instr (instr_r),
    .dec   (dec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_load) begin
        in_vld_r <= in_tvalid;
      end
      if (res_load) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_load && in_tvalid) begin
      instr_r <= in_tdata;
    end
    if (res_load && in_vld_r) begin
      res_r <= dec;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = res_r.format_class;
  assign out_tdata  = {1'b0, res_r.reg_list, res_r.extra_flag, res_r.neg_or_sp,
                       res_r.size_flag, res_r.load_flag, res_r.imm_is_reg,
                       res_r.immediate, res_r.offset_reg, res_r.src_reg,
                       res_r.dest_reg, res_r.op_code};

endmodule

@@ rtl/core/tifd_decode.sv @@
// format classifier and field extractor for one thumb instruction word
module tifd_decode
  import tifd_pkg::*;
(
  input  logic [InstrWidth-1:0] instr,
  output dec_t                  dec
);

  logic [2:0] low_d;
  logic [2:0] mid_s;
  logic [2:0] hi_d;

  assign low_d = instr[2:0];
  assign mid_s = instr[5:3];
  assign hi_d  = instr[10:8];

  always_comb begin
    dec              = '0;
    dec.format_class = FMT_UNDEFINED;
    // format tests in table order, first match wins
    priority if (instr[15:13] == 3'b000 && instr[12:11] != 2'b11) begin
      dec.format_class = FMT_MOVE_SHIFTED;
      dec.op_code      = {2'b00, instr[12:11]};
      dec.immediate    = {6'd0, instr[10:6]};
      dec.src_reg      = {1'b0, mid_s};
      dec.dest_reg     = {1'b0, low_d};
    end else if (instr[15:11] == 5'b00011) begin
      dec.format_class = FMT_ADD_SUB;
      dec.op_code      = {3'b000, instr[9]};
      dec.imm_is_reg   = ~instr[10];
      dec.offset_reg   = instr[8:6];
      dec.src_reg      = {1'b0, mid_s};
      dec.dest_reg     = {1'b0, low_d};
    end else if (instr[15:13] == 3'b001) begin
      dec.format_class = FMT_MOV_CMP_IMM;
      dec.op_code      = {2'b00, instr[12:11]};
      dec.dest_reg     = {1'b0, hi_d};
      dec.immediate    = {3'd0, instr[7:0]};
    end else if (instr[15:10] == 6'b010000) begin
      dec.format_class = FMT_ALU;
      dec.op_code      = instr[9:6];
      dec.src_reg      = {1'b0, mid_s};
      dec.dest_reg     = {1'b0, low_d};
    end else if (instr[15:10] == 6'b010001) begin
      dec.format_class = FMT_HI_REG_BX;
      dec.op_code      = {2'b00, instr[9:8]};
      dec.dest_reg     = {instr[7], low_d};
      dec.src_reg      = {instr[6], mid_s};
    end else if (instr[15:11] == 5'b01001) begin
      dec.format_class = FMT_PC_LOAD;
      dec.dest_reg     = {1'b0, hi_d};
      dec.immediate    = {3'd0, instr[7:0]};
    end else if (instr[15:12] == 4'b0101 && !instr[9]) begin
      dec.format_class = FMT_LS_REG_OFS;
      dec.load_flag    = instr[11];
      dec.size_flag    = instr[10];
      dec.offset_reg   = instr[8:6];
      dec.src_reg      = {1'b0, mid_s};
      dec.dest_reg     = {1'b0, low_d};
    end else if (instr[15:12] == 4'b0101) begin
      dec.format_class = FMT_LS_SIGN_EXT;
      dec.size_flag    = instr[11];
      dec.neg_or_sp    = instr[10];
      dec.offset_reg   = instr[8:6];
      dec.src_reg      = {1'b0, mid_s};
      dec.dest_reg     = {1'b0, low_d};
    end else if (instr[15:13] == 3'b011) begin
      dec.format_class = FMT_LS_IMM_OFS;
      dec.size_flag    = instr[12];
      dec.load_flag    = instr[11];
      dec.immediate    = {6'd0, instr[10:6]};
      dec.src_reg      = {1'b0, mid_s};
      dec.dest_reg     = {1'b0, low_d};
    end else if (instr[15:12] == 4'b1000) begin
      dec.format_class = FMT_LS_HALF;
      dec.load_flag    = instr[11];
      dec.immediate    = {6'd0, instr[10:6]};
      dec.src_reg      = {1'b0, mid_s};
      dec.dest_reg     = {1'b0, low_d};
    end else if (instr[15:12] == 4'b1001) begin
      dec.format_class = FMT_SP_LS;
      dec.load_flag    = instr[11];
      dec.dest_reg     = {1'b0, hi_d};
      dec.immediate    = {3'd0, instr[7:0]};
    end else if (instr[15:12] == 4'b1010) begin
      dec.format_class = FMT_LOAD_ADDR;
      dec.neg_or_sp    = instr[11];
      dec.dest_reg     = {1'b0, hi_d};
      dec.immediate    = {3'd0, instr[7:0]};
    end else if (instr[15:8] == 8'hB0) begin
      dec.format_class = FMT_SP_OFFSET;
      dec.neg_or_sp    = instr[7];
      dec.immediate    = {4'd0, instr[6:0]};
    end else if (instr[15:12] == 4'b1011 && instr[10:9] == 2'b10) begin
      dec.format_class = FMT_PUSH_POP;
      dec.load_flag    = instr[11];
      dec.extra_flag   = instr[8];
      dec.reg_list     = instr[7:0];
    end else if (instr[15:12] == 4'b1100) begin
      dec.format_class = FMT_MULTI_LS;
      dec.load_flag    = instr[11];
      dec.src_reg      = {1'b0, hi_d};
      dec.reg_list     = instr[7:0];
    end else if (instr[15:12] == 4'b1101 && instr[11:8] != 4'hF) begin
      dec.format_class = FMT_COND_BRANCH;
      dec.op_code      = instr[11:8];
      dec.immediate    = {3'd0, instr[7:0]};
    end else if (instr[15:8] == 8'hDF) begin
      dec.format_class = FMT_SWI;
      dec.immediate    = {3'd0, instr[7:0]};
    end else if (instr[15:11] == 5'b11100) begin
      dec.format_class = FMT_BRANCH;
      dec.immediate    = instr[10:0];
    end else if (instr[15:12] == 4'b1111) begin
      dec.format_class = FMT_LONG_BRANCH;
      dec.extra_flag   = instr[11];
      dec.immediate    = instr[10:0];
    end else begin
      // leftover 1011 patterns and 11101 stay undefined with zero fields
      dec.format_class = FMT_UNDEFINED;
    end
  end

endmodule

@@ tb/tb_thumb_instruction_field_decoder_core.sv @@
// self-checking testbench for the thumb instruction field decoder core
module tb_thumb_instruction_field_decoder_core;
  import tifd_pkg::*;

  localparam int unsigned RANDOM_WORDS = 1900;
  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned IDLE_PCT     = 10;
  localparam int unsigned TAIL_CYCLES  = 8;

  // one directed row: word, whether the expected fields are typed in, and those fields
  typedef struct {
    logic [15:0] word;
    bit          typed;
    dec_t        want;
  } dir_row_t;

  // an accepted word and the fields it should decode to
  typedef struct packed {
    logic [15:0] word;
    dec_t        fields;
  } pending_t;

  localparam dec_t NO_FIELDS    = '0;
  localparam dec_t LSL_ZERO     = '{FMT_MOVE_SHIFTED, 4'd0, 4'd0, 4'd0, 3'd0, 11'd0,
                                    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0};
  localparam dec_t UNDEF_FIELDS = '{FMT_UNDEFINED, 4'd0, 4'd0, 4'd0, 3'd0, 11'd0,
                                    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0};
  localparam dec_t BL_ALL_ONES  = '{FMT_LONG_BRANCH, 4'd0, 4'd0, 4'd0, 3'd0, 11'h7FF,
                                    1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'd0};

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [InDataBits-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OutDataBits-1:0] out_tdata;
  logic [ClassWidth-1:0]  out_tuser;

  pending_t    pending_decodes [$];
  int unsigned errors       = 0;
  int unsigned words_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count  = 0;
  logic [19:0] classes_hit  = '0;
  bit          calm         = 1'b0;
  bit          hold_request = 1'b0;

  dir_row_t dir_table [27] = '{
    '{16'h0000, 1'b1, LSL_ZERO},     // all-zero word
    '{16'hFFFF, 1'b1, BL_ALL_ONES},  // all-ones word, long branch low half
    '{16'hB100, 1'b1, UNDEF_FIELDS}, // 1011 hole next to sp offset
    '{16'hBE00, 1'b1, UNDEF_FIELDS}, // 1011 hole above push/pop
    '{16'hE800, 1'b1, UNDEF_FIELDS}, // 11101 prefix
    '{16'h17FF, 1'b0, NO_FIELDS},    // asr, all fields high
    '{16'h0FFF, 1'b0, NO_FIELDS},    // lsr
    '{16'h1800, 1'b0, NO_FIELDS},    // add register
    '{16'h1FFF, 1'b0, NO_FIELDS},    // sub immediate
    '{16'h3FFF, 1'b0, NO_FIELDS},    // sub 8-bit immediate
    '{16'h43FF, 1'b0, NO_FIELDS},    // alu mvn
    '{16'h4780, 1'b0, NO_FIELDS},    // bx with h1 set
    '{16'h4400, 1'b0, NO_FIELDS},    // hi add with both h bits clear
    '{16'h4FFF, 1'b0, NO_FIELDS},    // pc-relative load
    '{16'h5E00, 1'b0, NO_FIELDS},    // ldsh
    '{16'h5C00, 1'b0, NO_FIELDS},    // ldrb register offset
    '{16'h7FFF, 1'b0, NO_FIELDS},    // ldrb immediate offset
    '{16'h8FFF, 1'b0, NO_FIELDS},    // ldrh
    '{16'h9FFF, 1'b0, NO_FIELDS},    // sp-relative load
    '{16'hAFFF, 1'b0, NO_FIELDS},    // load address from sp
    '{16'hB0FF, 1'b0, NO_FIELDS},    // negative sp offset
    '{16'hBDFF, 1'b0, NO_FIELDS},    // pop with pc
    '{16'hCFFF, 1'b0, NO_FIELDS},    // ldmia
    '{16'hDEFF, 1'b0, NO_FIELDS},    // condition 1110 stays a branch
    '{16'hDFFF, 1'b0, NO_FIELDS},    // condition 1111 is swi
    '{16'hE7FF, 1'b0, NO_FIELDS},    // unconditional branch
    '{16'hF000, 1'b0, NO_FIELDS}     // long branch high half
  };

  thumb_instruction_field_decoder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d decodes still pending", $time, pending_decodes.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // format table in priority order; fields a format does not define stay zero
  function automatic dec_t decode_thumb(input logic [15:0] w);
    dec_t d;
    d = '0;
    d.format_class = FMT_UNDEFINED;
    if (w[15:13] == 3'b000 && w[12:11] != 2'b11) begin
      d.format_class = FMT_MOVE_SHIFTED;
      d.op_code = {2'b00, w[12:11]};
      d.immediate = {6'd0, w[10:6]};
      d.src_reg = {1'b0, w[5:3]};
      d.dest_reg = {1'b0, w[2:0]};
    end else if (w[15:11] == 5'b00011) begin
      d.format_class = FMT_ADD_SUB;
      d.op_code = {3'b000, w[9]};
      d.imm_is_reg = ~w[10];
      d.offset_reg = w[8:6];
      d.src_reg = {1'b0, w[5:3]};
      d.dest_reg = {1'b0, w[2:0]};
    end else if (w[15:13] == 3'b001) begin
      d.format_class = FMT_MOV_CMP_IMM;
      d.op_code = {2'b00, w[12:11]};
      d.dest_reg = {1'b0, w[10:8]};
      d.immediate = {3'd0, w[7:0]};
    end else if (w[15:10] == 6'b010000) begin
      d.format_class = FMT_ALU;
      d.op_code = w[9:6];
      d.src_reg = {1'b0, w[5:3]};
      d.dest_reg = {1'b0, w[2:0]};
    end else if (w[15:10] == 6'b010001) begin
      d.format_class = FMT_HI_REG_BX;
      d.op_code = {2'b00, w[9:8]};
      d.dest_reg = {w[7], w[2:0]};
      d.src_reg = {w[6], w[5:3]};
    end else if (w[15:11] == 5'b01001) begin
      d.format_class = FMT_PC_LOAD;
      d.dest_reg = {1'b0, w[10:8]};
      d.immediate = {3'd0, w[7:0]};
    end else if (w[15:12] == 4'b0101 && !w[9]) begin
      d.format_class = FMT_LS_REG_OFS;
      d.load_flag = w[11];
      d.size_flag = w[10];
      d.offset_reg = w[8:6];
      d.src_reg = {1'b0, w[5:3]};
      d.dest_reg = {1'b0, w[2:0]};
    end else if (w[15:12] == 4'b0101) begin
      d.format_class = FMT_LS_SIGN_EXT;
      d.size_flag = w[11];
      d.neg_or_sp = w[10];
      d.offset_reg = w[8:6];
      d.src_reg = {1'b0, w[5:3]};
      d.dest_reg = {1'b0, w[2:0]};
    end else if (w[15:13] == 3'b011) begin
      d.format_class = FMT_LS_IMM_OFS;
      d.size_flag = w[12];
      d.load_flag = w[11];
      d.immediate = {6'd0, w[10:6]};
      d.src_reg = {1'b0, w[5:3]};
      d.dest_reg = {1'b0, w[2:0]};
    end else if (w[15:12] == 4'b1000) begin
      d.format_class = FMT_LS_HALF;
      d.load_flag = w[11];
      d.immediate = {6'd0, w[10:6]};
      d.src_reg = {1'b0, w[5:3]};
      d.dest_reg = {1'b0, w[2:0]};
    end else if (w[15:12] == 4'b1001) begin
      d.format_class = FMT_SP_LS;
      d.load_flag = w[11];
      d.dest_reg = {1'b0, w[10:8]};
      d.immediate = {3'd0, w[7:0]};
    end else if (w[15:12] == 4'b1010) begin
      d.format_class = FMT_LOAD_ADDR;
      d.neg_or_sp = w[11];
      d.dest_reg = {1'b0, w[10:8]};
      d.immediate = {3'd0, w[7:0]};
    end else if (w[15:8] == 8'hB0) begin
      d.format_class = FMT_SP_OFFSET;
      d.neg_or_sp = w[7];
      d.immediate = {4'd0, w[6:0]};
    end else if (w[15:12] == 4'hB && w[10:9] == 2'b10) begin
      d.format_class = FMT_PUSH_POP;
      d.load_flag = w[11];
      d.extra_flag = w[8];
      d.reg_list = w[7:0];
    end else if (w[15:12] == 4'hC) begin
      d.format_class = FMT_MULTI_LS;
      d.load_flag = w[11];
      d.src_reg = {1'b0, w[10:8]};
      d.reg_list = w[7:0];
    end else if (w[15:12] == 4'hD && w[11:8] != 4'hF) begin
      d.format_class = FMT_COND_BRANCH;
      d.op_code = w[11:8];
      d.immediate = {3'd0, w[7:0]};
    end else if (w[15:8] == 8'hDF) begin
      d.format_class = FMT_SWI;
      d.immediate = {3'd0, w[7:0]};
    end else if (w[15:11] == 5'b11100) begin
      d.format_class = FMT_BRANCH;
      d.immediate = w[10:0];
    end else if (w[15:12] == 4'hF) begin
      d.format_class = FMT_LONG_BRANCH;
      d.extra_flag = w[11];
      d.immediate = w[10:0];
    end
    return d;
  endfunction

  task automatic compare_field(input string name, input logic [15:0] word,
                               input logic [10:0] want, input logic [10:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: word %h field %s expected %h got %h", $time, word, name, want, got);
    end
  endtask

  // drive one word, with a random gap ahead of it, and log its decode once accepted
  task automatic offer_word(input logic [15:0] w, input bit typed, input dec_t want);
    pending_t p;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    do @(posedge clk); while (!in_tready);
    p.word   = w;
    p.fields = typed ? want : decode_thumb(w);
    pending_decodes.push_back(p);
    words_sent++;
  endtask

  // result side: check each beat, then pick tready for the next cycle
  initial begin
    pending_t   exp_beat;
    dec_t       got;
    int unsigned hold_left;
    hold_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        results_seen++;
        got.format_class = out_tuser;
        got.op_code      = out_tdata[3:0];
        got.dest_reg     = out_tdata[7:4];
        got.src_reg      = out_tdata[11:8];
        got.offset_reg   = out_tdata[14:12];
        got.immediate    = out_tdata[25:15];
        got.imm_is_reg   = out_tdata[26];
        got.load_flag    = out_tdata[27];
        got.size_flag    = out_tdata[28];
        got.neg_or_sp    = out_tdata[29];
        got.extra_flag   = out_tdata[30];
        got.reg_list     = out_tdata[38:31];
        if (pending_decodes.size() == 0) begin
          errors++;
          $display("%0t: result beat with no word pending, tuser %h tdata %h",
                   $time, out_tuser, out_tdata);
        end else begin
          exp_beat = pending_decodes.pop_front();
          if (got.format_class < 20) classes_hit[got.format_class] = 1'b1;
          compare_field("format_class", exp_beat.word, 11'(exp_beat.fields.format_class),
                        11'(got.format_class));
          compare_field("op_code", exp_beat.word, 11'(exp_beat.fields.op_code),
                        11'(got.op_code));
          compare_field("dest_reg", exp_beat.word, 11'(exp_beat.fields.dest_reg),
                        11'(got.dest_reg));
          compare_field("src_reg", exp_beat.word, 11'(exp_beat.fields.src_reg),
                        11'(got.src_reg));
          compare_field("offset_reg", exp_beat.word, 11'(exp_beat.fields.offset_reg),
                        11'(got.offset_reg));
          compare_field("immediate", exp_beat.word, exp_beat.fields.immediate,
                        got.immediate);
          compare_field("imm_is_reg", exp_beat.word, 11'(exp_beat.fields.imm_is_reg),
                        11'(got.imm_is_reg));
          compare_field("load_flag", exp_beat.word, 11'(exp_beat.fields.load_flag),
                        11'(got.load_flag));
          compare_field("size_flag", exp_beat.word, 11'(exp_beat.fields.size_flag),
                        11'(got.size_flag));
          compare_field("neg_or_sp", exp_beat.word, 11'(exp_beat.fields.neg_or_sp),
                        11'(got.neg_or_sp));
          compare_field("extra_flag", exp_beat.word, 11'(exp_beat.fields.extra_flag),
                        11'(got.extra_flag));
          compare_field("reg_list", exp_beat.word, 11'(exp_beat.fields.reg_list),
                        11'(got.reg_list));
          compare_field("tdata pad", exp_beat.word, 11'd0, {10'd0, out_tdata[39]});
        end
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (hold_request) begin
        // long back-pressure so the input side fills and stalls
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // input side: reset, directed table, then biased random words
  initial begin
    logic [15:0] w;
    logic [4:0]  pick;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_table[i]) offer_word(dir_table[i].word, dir_table[i].typed, dir_table[i].want);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      calm = (n >= 700 && n < 1100);
      if (n == 300) hold_request = 1'b1;
      if (n == 1400) begin
        // pause the sender until every decode has come back
        in_tvalid <= 1'b0;
        do @(posedge clk); while (pending_decodes.size() != 0);
      end
      w = 16'($urandom);
      pick = 5'($urandom_range(0, 23));
      // most words are steered into one format, random elsewhere
      case (pick)
        FMT_MOVE_SHIFTED: begin
          w[15:13] = 3'b000;
          if (w[12:11] == 2'b11) w[12] = 1'b0;
        end
        FMT_ADD_SUB:     w[15:11] = 5'b00011;
        FMT_MOV_CMP_IMM: w[15:13] = 3'b001;
        FMT_ALU:         w[15:10] = 6'b010000;
        FMT_HI_REG_BX:   w[15:10] = 6'b010001;
        FMT_PC_LOAD:     w[15:11] = 5'b01001;
        FMT_LS_REG_OFS: begin
          w[15:12] = 4'b0101;
          w[9] = 1'b0;
        end
        FMT_LS_SIGN_EXT: begin
          w[15:12] = 4'b0101;
          w[9] = 1'b1;
        end
        FMT_LS_IMM_OFS:  w[15:13] = 3'b011;
        FMT_LS_HALF:     w[15:12] = 4'b1000;
        FMT_SP_LS:       w[15:12] = 4'b1001;
        FMT_LOAD_ADDR:   w[15:12] = 4'b1010;
        FMT_SP_OFFSET:   w[15:8] = 8'hB0;
        FMT_PUSH_POP: begin
          w[15:12] = 4'hB;
          w[10:9] = 2'b10;
        end
        FMT_MULTI_LS:    w[15:12] = 4'hC;
        FMT_COND_BRANCH: w[15:12] = 4'hD;
        FMT_SWI:         w[15:8] = 8'hDF;
        FMT_BRANCH:      w[15:11] = 5'b11100;
        FMT_LONG_BRANCH: w[15:12] = 4'hF;
        FMT_UNDEFINED: begin
          if (w[0]) begin
            w[15:11] = 5'b11101;
          end else begin
            // land in one of the 1011 holes
            w[15:12] = 4'hB;
            if (w[10:9] == 2'b10) w[10] = 1'b1;
            if (w[11:8] == 4'h0) w[8] = 1'b1;
          end
        end
        default: ;
      endcase
      offer_word(w, 1'b0, NO_FIELDS);
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;

    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("decoded %0d words (directed and random), %0d result beats compared",
             words_sent, results_seen);
    $display("format classes seen: %0d of 20, mismatches: %0d", $countones(classes_hit),
             errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/tifd_pkg.sv
rtl/core/tifd_decode.sv
rtl/core/thumb_instruction_field_decoder_core.sv
tb/tb_thumb_instruction_field_decoder_core.sv
